/* sv/sart_pkg.sv */
// shared types and codes for the stream ack range tracker
`default_nettype none
package sart_pkg;
    localparam int W = 62;
    typedef logic [W-1:0] off_t;
    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_REG = 3'd0;
    localparam cmd_t CMD_SENT = 3'd1;
    localparam cmd_t CMD_ACK = 3'd2;
    localparam cmd_t CMD_UNREG = 3'd3;
    localparam cmd_t CMD_QUERY = 3'd4;
    typedef logic [2:0] stat_t;
    localparam stat_t ST_OK = 3'd0;
    localparam stat_t ST_UNKNOWN = 3'd1;
    localparam stat_t ST_DUP = 3'd2;
    localparam stat_t ST_FULL = 3'd3;
    localparam stat_t ST_RFULL = 3'd4;
    localparam stat_t ST_OVF = 3'd5;
    // one stored acknowledged range held in a cell of the ring
    typedef struct packed {
        logic valid;
        off_t lo;
        off_t hi;
    } rng_t;
    // merge beat travelling with the ring
    typedef struct packed {
        logic active;
        off_t lo;
        off_t hi;
        logic merged;
    } mrg_t;
endpackage
`default_nettype wire

/* sv/sart_cell.sv */
// one range cell: holds one stored range and merges it with the passing ack beat
`default_nettype none
module sart_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire logic            clr,
    input  wire logic            load,
    input  wire sart_pkg::rng_t  load_val,
    input  wire sart_pkg::mrg_t  mrg_in,
    output sart_pkg::rng_t       rng_out,
    output sart_pkg::mrg_t       mrg_out
);
    sart_pkg::rng_t rng_reg;
    sart_pkg::rng_t rng_next;
    sart_pkg::mrg_t mrg_reg;
    sart_pkg::mrg_t mrg_next;
    logic hit;

    // the stored range stays put, the ack beat moves on to the next cell
    always_comb
    begin
        hit = mrg_in.active && rng_reg.valid && rng_reg.lo <= mrg_in.hi
              && mrg_in.lo <= rng_reg.hi;
        mrg_next = mrg_in;
        rng_next = rng_reg;
        if (hit)
        begin
            if (rng_reg.lo < mrg_in.lo) mrg_next.lo = rng_reg.lo;
            if (rng_reg.hi > mrg_in.hi) mrg_next.hi = rng_reg.hi;
            mrg_next.merged = 1'b1;
            rng_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg.valid <= 1'b0;
            mrg_reg.active <= 1'b0;
        end
        else if (clr)
        begin
            rng_reg.valid <= 1'b0;
            mrg_reg.active <= 1'b0;
        end
        else if (load)
            rng_reg <= load_val;
        else if (shift)
        begin
            rng_reg <= rng_next;
            mrg_reg <= mrg_next;
        end
    end

    assign rng_out = rng_reg;
    assign mrg_out = mrg_reg;
endmodule
`default_nettype wire

/* sv/stream_ack_range_tracker_top.sv */
// top level of the per-stream send and acknowledgement tracker
// Each input beat is one command for a stream. Streams live in NUM_STREAMS
// slots whose ids, data start, sent end and ack prefix are held in flops and
// searched combinationally. Out-of-order acknowledged ranges live in a row of
// MAX_RANGES cells per slot; on an ack that reaches past the prefix the ack
// range walks down the row of the addressed slot, one cell per cycle, and
// swallows every overlapping or touching range on its way. A command that
// walks the row is taken in S_IDLE, looked up in S_LOOK, walked in S_ROT and
// finished in S_FIN, where its result is written; every other command skips
// S_ROT. No new beat is taken before the last one has left S_FIN. The result
// sits in an output register, so the next beat is taken and worked on while
// the result waits; only its finishing cycle is held until the output
// register is free. Only the active slot's row moves.
`default_nettype none
module stream_ack_range_tracker_top #(
    parameter int NUM_STREAMS = 16,
    parameter int MAX_RANGES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [61:0] flow_id,
    input  wire logic [61:0] byte_offset,
    input  wire logic [61:0] byte_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [61:0]      sent_bytes,
    output logic [61:0]      bytes_acked
);
    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int RW = $clog2(MAX_RANGES + 1);
    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_ROT  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [NUM_STREAMS-1:0] sv_reg;
    sart_pkg::off_t id_reg [NUM_STREAMS];
    sart_pkg::off_t ds_reg [NUM_STREAMS];
    sart_pkg::off_t se_reg [NUM_STREAMS];
    sart_pkg::off_t ap_reg [NUM_STREAMS];

    sart_pkg::cmd_t cmd_reg;
    sart_pkg::off_t sid_reg, off_reg, cnt_reg;
    logic [SW-1:0] slot_reg;
    logic found_reg;
    logic rot_reg;
    logic [RW-1:0] cnt_rot_reg;
    logic res_valid_reg;
    sart_pkg::stat_t st_reg;
    sart_pkg::off_t bs_reg, ba_reg;

    sart_pkg::rng_t rng_o [NUM_STREAMS][MAX_RANGES];
    sart_pkg::mrg_t mrg_o [NUM_STREAMS][MAX_RANGES];
    logic [NUM_STREAMS-1:0] shift_s, clr_s;
    logic [NUM_STREAMS-1:0][MAX_RANGES-1:0] load_c;
    sart_pkg::rng_t load_v;
    sart_pkg::mrg_t inj;

    // combinational slot search
    logic hit_any, free_any;
    logic [SW-1:0] hit_idx, free_idx;
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int s = NUM_STREAMS - 1; s >= 0; s--)
        begin
            if (sv_reg[s] && id_reg[s] == sid_reg)
            begin
                hit_any = 1'b1;
                hit_idx = SW'(s);
            end
            if (!sv_reg[s])
            begin
                free_any = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    logic [62:0] end_w;
    assign end_w = {1'b0, off_reg} + {1'b0, cnt_reg};

    // ack lo raised to the prefix
    sart_pkg::off_t ack_lo;
    assign ack_lo = (off_reg < ap_reg[slot_reg]) ? ap_reg[slot_reg] : off_reg;

    // an ack that reaches past the prefix walks the row
    logic go_rot;
    assign go_rot = cmd_reg == sart_pkg::CMD_ACK && hit_any && cnt_reg != '0
                    && !end_w[62] && end_w[61:0] > ap_reg[hit_idx];

    // the finishing cycle waits until the output register is free
    logic fin_go;
    assign fin_go = !res_valid_reg || out_ready;

    genvar gs, gr;
    generate
        for (gs = 0; gs < NUM_STREAMS; gs++)
        begin : g_s
            for (gr = 0; gr < MAX_RANGES; gr++)
            begin : g_r
                localparam int P = (gr + MAX_RANGES - 1) % MAX_RANGES;
                sart_pkg::mrg_t mi;
                assign mi = (gr == 0) ? inj : mrg_o[gs][P];
                sart_cell u_cell (
                    .clk(clk), .rst_n(rst_n),
                    .shift(shift_s[gs]), .clr(clr_s[gs]),
                    .load(load_c[gs][gr]), .load_val(load_v),
                    .mrg_in(mi),
                    .rng_out(rng_o[gs][gr]), .mrg_out(mrg_o[gs][gr])
                );
            end
        end
    endgenerate

    // the beat leaving the last cell after the full walk
    sart_pkg::mrg_t mrg_end;
    assign mrg_end = mrg_o[slot_reg][MAX_RANGES-1];

    // first free cell of the slot after the walk
    logic rfree_any;
    logic [IW-1:0] rfree_idx;
    always_comb
    begin
        rfree_any = 1'b0;
        rfree_idx = '0;
        for (int r = MAX_RANGES - 1; r >= 0; r--)
            if (!rng_o[slot_reg][r].valid)
            begin
                rfree_any = 1'b1;
                rfree_idx = IW'(r);
            end
    end

    function automatic sart_pkg::off_t fsent(sart_pkg::off_t se, sart_pkg::off_t ds);
        return (se >= ds) ? se - ds : '0;
    endfunction

    function automatic sart_pkg::off_t facked(sart_pkg::off_t se, sart_pkg::off_t ds,
                                              sart_pkg::off_t ap);
        sart_pkg::off_t s;
        sart_pkg::off_t a;
        s = (se >= ds) ? se - ds : '0;
        a = ap - ds;
        return (a > s) ? s : a;
    endfunction

    // result and slot update of the finishing cycle
    sart_pkg::stat_t st_next;
    sart_pkg::off_t se_next, ap_next, ds_cur, bs_next, ba_next;
    logic store_rng;
    always_comb
    begin
        st_next = sart_pkg::ST_OK;
        se_next = se_reg[slot_reg];
        ap_next = ap_reg[slot_reg];
        ds_cur = ds_reg[slot_reg];
        store_rng = 1'b0;
        if (cmd_reg == sart_pkg::CMD_REG)
        begin
            if (found_reg)
                st_next = sart_pkg::ST_DUP;
            else if (!free_any)
                st_next = sart_pkg::ST_FULL;
            else
            begin
                // fresh slot
                se_next = '0;
                ap_next = off_reg;
                ds_cur = off_reg;
            end
        end
        else if (!found_reg)
            st_next = sart_pkg::ST_UNKNOWN;
        else if ((cmd_reg == sart_pkg::CMD_SENT || cmd_reg == sart_pkg::CMD_ACK)
                 && cnt_reg != '0)
        begin
            if (end_w[62])
                st_next = sart_pkg::ST_OVF;
            else if (cmd_reg == sart_pkg::CMD_SENT)
            begin
                if (end_w[61:0] > se_next) se_next = end_w[61:0];
            end
            else if (rot_reg)
            begin
                if (mrg_end.lo <= ap_next)
                    ap_next = mrg_end.hi;
                else if (rfree_any)
                    store_rng = 1'b1;
                else if (!mrg_end.merged)
                    st_next = sart_pkg::ST_RFULL;
            end
        end
        if (st_next == sart_pkg::ST_UNKNOWN || st_next == sart_pkg::ST_FULL)
        begin
            bs_next = '0;
            ba_next = '0;
        end
        else
        begin
            bs_next = fsent(se_next, ds_cur);
            ba_next = facked(se_next, ds_cur, ap_next);
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = res_valid_reg;
    assign status = st_reg;
    assign sent_bytes = bs_reg;
    assign bytes_acked = ba_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_LOOK;
            S_LOOK: state_next = go_rot ? S_ROT : S_FIN;
            S_ROT: if (cnt_rot_reg == RW'(MAX_RANGES)) state_next = S_FIN;
            S_FIN: if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // the row shifts MAX_RANGES times; beat injected at the first shift
    always_comb
    begin
        shift_s = '0;
        clr_s = '0;
        load_c = '0;
        load_v.valid = 1'b1;
        load_v.lo = mrg_end.lo;
        load_v.hi = mrg_end.hi;
        inj.active = (cnt_rot_reg == '0);
        inj.lo = ack_lo;
        inj.hi = end_w[61:0];
        inj.merged = 1'b0;
        if (state_reg == S_ROT && cnt_rot_reg != RW'(MAX_RANGES))
            shift_s[slot_reg] = 1'b1;
        if (state_reg == S_FIN && fin_go)
        begin
            if (store_rng)
                load_c[slot_reg][rfree_idx] = 1'b1;
            if (found_reg && cmd_reg == sart_pkg::CMD_UNREG)
                clr_s[slot_reg] = 1'b1;
            if (!found_reg && cmd_reg == sart_pkg::CMD_REG && free_any)
                clr_s[slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sv_reg <= '0;
            res_valid_reg <= 1'b0;
            cnt_rot_reg <= '0;
            found_reg <= 1'b0;
            rot_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && fin_go)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= command;
                        sid_reg <= flow_id;
                        off_reg <= byte_offset;
                        cnt_reg <= byte_count;
                    end
                end
                S_LOOK:
                begin
                    found_reg <= hit_any;
                    slot_reg <= hit_any ? hit_idx : free_idx;
                    rot_reg <= go_rot;
                    cnt_rot_reg <= '0;
                end
                S_ROT:
                begin
                    if (cnt_rot_reg != RW'(MAX_RANGES))
                        cnt_rot_reg <= cnt_rot_reg + RW'(1);
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        st_reg <= st_next;
                        bs_reg <= bs_next;
                        ba_reg <= ba_next;
                        if (cmd_reg == sart_pkg::CMD_REG)
                        begin
                            if (!found_reg && free_any)
                            begin
                                sv_reg[slot_reg] <= 1'b1;
                                id_reg[slot_reg] <= sid_reg;
                                ds_reg[slot_reg] <= off_reg;
                                se_reg[slot_reg] <= se_next;
                                ap_reg[slot_reg] <= ap_next;
                            end
                        end
                        else if (found_reg)
                        begin
                            se_reg[slot_reg] <= se_next;
                            ap_reg[slot_reg] <= ap_next;
                            if (cmd_reg == sart_pkg::CMD_UNREG)
                                sv_reg[slot_reg] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/stream_ack_range_tracker_top_tb.sv */
// self-checking testbench for the stream ack range tracker top level
`default_nettype none
module stream_ack_range_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTR = 16;
    localparam int NRNG = 8;
    localparam logic [63:0] MASK62 = (64'd1 << 62) - 64'd1;

    // result fields expected for one beat
    typedef struct {
        sart_pkg::stat_t st;
        sart_pkg::off_t  sent;
        sart_pkg::off_t  acked;
    } tracker_result_t;

    // stream table mirror plus the queue of pending results
    class tracker_scoreboard;
        bit          slot_on [NSTR];
        logic [63:0] slot_id [NSTR];
        logic [63:0] start_off [NSTR];
        logic [63:0] sent_off [NSTR];
        logic [63:0] prefix_off [NSTR];
        bit          rng_on [NSTR][NRNG];
        logic [63:0] rng_lo [NSTR][NRNG];
        logic [63:0] rng_hi [NSTR][NRNG];
        tracker_result_t pending[$];
        int errors;
        int checked;

        function void clear();
            foreach (slot_on[s])
            begin
                slot_on[s] = 0;
                foreach (rng_on[s][r]) rng_on[s][r] = 0;
            end
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function int lookup(logic [63:0] id);
            for (int s = 0; s < NSTR; s++)
                if (slot_on[s] && slot_id[s] == id) return s;
            return -1;
        endfunction

        function void fill_stats(int s, ref tracker_result_t r);
            logic [63:0] sn;
            logic [63:0] ak;
            sn = 0;
            if (sent_off[s] >= start_off[s]) sn = sent_off[s] - start_off[s];
            ak = (prefix_off[s] - start_off[s]) & MASK62;
            if (ak > sn) ak = sn;
            r.sent = sn[61:0];
            r.acked = ak[61:0];
        endfunction

        function sart_pkg::stat_t merge_ack(int s, logic [63:0] lo, logic [63:0] hi);
            bit merged;
            int fr;
            merged = 0;
            fr = -1;
            if (lo < prefix_off[s]) lo = prefix_off[s];
            for (int r = 0; r < NRNG; r++)
                if (rng_on[s][r] && rng_lo[s][r] <= hi && lo <= rng_hi[s][r])
                begin
                    if (rng_lo[s][r] < lo) lo = rng_lo[s][r];
                    if (rng_hi[s][r] > hi) hi = rng_hi[s][r];
                    rng_on[s][r] = 0;
                    merged = 1;
                end
            if (lo <= prefix_off[s])
            begin
                prefix_off[s] = hi;
                return sart_pkg::ST_OK;
            end
            for (int r = 0; r < NRNG; r++)
                if (!rng_on[s][r])
                begin
                    fr = r;
                    break;
                end
            if (fr < 0) return merged ? sart_pkg::ST_OK : sart_pkg::ST_RFULL;
            rng_lo[s][fr] = lo;
            rng_hi[s][fr] = hi;
            rng_on[s][fr] = 1;
            return sart_pkg::ST_OK;
        endfunction

        // note an accepted command beat and queue its result
        function void note_command(sart_pkg::cmd_t c, sart_pkg::off_t id,
                                   sart_pkg::off_t off, sart_pkg::off_t cnt);
            tracker_result_t r;
            logic [63:0] e;
            int s;
            int k;
            r.st = sart_pkg::ST_OK;
            r.sent = 0;
            r.acked = 0;
            e = {2'b0, off} + {2'b0, cnt};
            s = lookup({2'b0, id});
            if (c == sart_pkg::CMD_REG)
            begin
                if (s >= 0)
                begin
                    r.st = sart_pkg::ST_DUP;
                    fill_stats(s, r);
                end
                else
                begin
                    for (k = 0; k < NSTR; k++)
                        if (!slot_on[k]) break;
                    if (k >= NSTR) r.st = sart_pkg::ST_FULL;
                    else
                    begin
                        slot_on[k] = 1;
                        slot_id[k] = {2'b0, id};
                        start_off[k] = {2'b0, off};
                        sent_off[k] = 0;
                        prefix_off[k] = {2'b0, off};
                        foreach (rng_on[k][q]) rng_on[k][q] = 0;
                        fill_stats(k, r);
                    end
                end
            end
            else if (s < 0) r.st = sart_pkg::ST_UNKNOWN;
            else
            begin
                if ((c == sart_pkg::CMD_SENT || c == sart_pkg::CMD_ACK) && cnt != 0)
                begin
                    if (e > MASK62) r.st = sart_pkg::ST_OVF;
                    else if (c == sart_pkg::CMD_SENT)
                    begin
                        if (e > sent_off[s]) sent_off[s] = e;
                    end
                    else if (e > prefix_off[s]) r.st = merge_ack(s, {2'b0, off}, e);
                end
                fill_stats(s, r);
                if (c == sart_pkg::CMD_UNREG)
                begin
                    slot_on[s] = 0;
                    foreach (rng_on[s][q]) rng_on[s][q] = 0;
                end
            end
            pending.push_back(r);
        endfunction

        // compare one result beat against the oldest expectation
        task check_result(sart_pkg::stat_t st, sart_pkg::off_t sn, sart_pkg::off_t ak);
            tracker_result_t x;
            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("result beat with nothing pending");
                return;
            end
            x = pending.pop_front();
            if (st != x.st)
                report_mismatch($sformatf("status got %0d want %0d", st, x.st));
            if (sn != x.sent)
                report_mismatch($sformatf("sent_bytes got %0h want %0h", sn, x.sent));
            if (ak != x.acked)
                report_mismatch($sformatf("bytes_acked got %0h want %0h", ak, x.acked));
        endtask

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [61:0] flow_id;
    logic [61:0] byte_offset;
    logic [61:0] byte_count;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [61:0] sent_bytes;
    logic [61:0] bytes_acked;

    tracker_scoreboard sb;
    int items_sent;
    logic [61:0] id_pool [6];

    stream_ack_range_tracker_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .flow_id(flow_id),
        .byte_offset(byte_offset), .byte_count(byte_count),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .sent_bytes(sent_bytes), .bytes_acked(bytes_acked)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function logic [61:0] rand62();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[61:0];
    endfunction

    // one command beat: hold valid until accepted, note it in the scoreboard
    task automatic send_beat(sart_pkg::cmd_t c, logic [61:0] id, logic [61:0] off,
                             logic [61:0] cnt, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        flow_id <= id;
        byte_offset <= off;
        byte_count <= cnt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_command(c, id, off, cnt);
        items_sent++;
    endtask

    // sender hold-off until every pending result has drained
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // receiver side: random stalls on out_ready, checks on every beat
    initial
    begin
        int hold;
        hold = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(status, sent_bytes, bytes_acked);
            if (hold > 0)
                hold--;
            else if (!out_ready)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 99) < 30)
            begin
                hold = gap_len();
                if (hold > 0) out_ready <= 1'b0;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [61:0] base;
        logic [61:0] top;
        int p;
        int n;
        sart_pkg::cmd_t c;
        logic [61:0] id;
        sb = new();
        sb.clear();
        items_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = sart_pkg::CMD_QUERY;
        flow_id = '0;
        byte_offset = '0;
        byte_count = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown stream, register, duplicate, zero count, overflow
        top = '1;
        send_beat(sart_pkg::CMD_QUERY, 62'd5, 62'd0, 62'd0);
        send_beat(sart_pkg::CMD_REG, 62'd5, 62'd100, 62'd0);
        send_beat(sart_pkg::CMD_REG, 62'd5, 62'd7, 62'd0);
        send_beat(sart_pkg::CMD_SENT, 62'd5, 62'd100, 62'd0);
        send_beat(sart_pkg::CMD_SENT, 62'd5, top, 62'd1);
        send_beat(sart_pkg::CMD_ACK, 62'd5, top, top);
        send_beat(sart_pkg::CMD_SENT, 62'd5, 62'd100, 62'd1000);
        // out-of-order acks: gap, touching, below prefix, then prefix catch-up
        send_beat(sart_pkg::CMD_ACK, 62'd5, 62'd300, 62'd50);
        send_beat(sart_pkg::CMD_ACK, 62'd5, 62'd350, 62'd50);
        send_beat(sart_pkg::CMD_ACK, 62'd5, 62'd500, 62'd10);
        send_beat(sart_pkg::CMD_ACK, 62'd5, 62'd0, 62'd50);
        send_beat(sart_pkg::CMD_ACK, 62'd5, 62'd100, 62'd250);
        // fill the range store of one stream and go past it
        for (int i = 0; i < 9; i++)
            send_beat(sart_pkg::CMD_ACK, 62'd5, 62'd2000 + 62'(i) * 62'd20, 62'd5);
        send_beat(sart_pkg::CMD_QUERY, 62'd5, 62'd0, 62'd0);
        send_beat(3'd7, 62'd5, 62'd0, 62'd0);
        send_beat(sart_pkg::CMD_UNREG, 62'd5, 62'd0, 62'd0);
        send_beat(sart_pkg::CMD_UNREG, 62'd5, 62'd0, 62'd0);
        // table full and extreme ids and offsets
        for (int i = 0; i < 17; i++)
            send_beat(sart_pkg::CMD_REG, (i == 0) ? top : 62'(i + 40),
                      (i == 1) ? top : 62'(i), 62'd0, 1);
        drain();
        for (int i = 0; i < 16; i++)
            send_beat(sart_pkg::CMD_UNREG, (i == 0) ? top : 62'(i + 40),
                      62'd0, 62'd0, 1);
        drain();

        // random: well-formed sessions over a small id pool, plus noise
        foreach (id_pool[i]) id_pool[i] = rand62();
        n = 0;
        while (n < 490)
        begin
            id = id_pool[$urandom_range(0, 5)];
            base = 62'($urandom_range(0, 4000));
            p = $urandom_range(0, 99);
            if (p < 10) c = sart_pkg::CMD_REG;
            else if (p < 35) c = sart_pkg::CMD_SENT;
            else if (p < 80) c = sart_pkg::CMD_ACK;
            else if (p < 86) c = sart_pkg::CMD_UNREG;
            else c = 3'($urandom_range(4, 7));
            if ($urandom_range(0, 19) == 0) id = rand62();
            if ($urandom_range(0, 29) == 0)
                send_beat(c, id, rand62(), rand62());
            else
                send_beat(c, id, base, 62'($urandom_range(0, 300)));
            n++;
            if (n == 245) drain();
        end
        drain();
        repeat (30) @(posedge clk);
        $display("ran %0d command beats, %0d results checked", items_sent, sb.checked);
        $display("covered every command, unused codes, table and range store full, overflow");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** stream_ack_range_tracker_top: PASSED **");
        else
            $display("** stream_ack_range_tracker_top: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #3ms;
        $display("timeout");
        $display("** stream_ack_range_tracker_top: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
sv/sart_pkg.sv
sv/sart_cell.sv
sv/stream_ack_range_tracker_top.sv
tb/stream_ack_range_tracker_top_tb.sv
